/* src/positional_list_engine_top_assert.svh */
// assertion macros for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during reset
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");
// next-cycle implication, sampled on clk, quiet during reset
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");
`else
`define PLE_ASSERT_NOW(label, ante, cons)
`define PLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/ple_pkg.sv */
// shared types and codes of the positional list engine
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_INS_END   = 3'd0,
    OP_INS_BEGIN = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_COUNT     = 3'd7
  } op_t;

  // status codes of a result beat
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam int unsigned FIELD_W = 9;
  localparam int unsigned DATA_W  = 32;

endpackage

`default_nettype wire

/* src/positional_list_engine_top.sv */
// positional list engine: ordered list in a single-port-write memory with shift sequencer
//
//   channel  | ports                                         | flow
//   ---------+-----------------------------------------------+----------------------
//   input    | start, busy, in_op, in_item_value, in_list_position | start && !busy
//   result   | out_valid, out_status, out_found_position, out_list_length | strobe
//
// count and every rejected insert or delete come back in the cycle after the beat is taken.
// insert at zero-based slot i shifts slots i to the last up by one, then writes the item.
// delete at zero-based slot i shifts the slots above i down by one.
// search reads from position 1 up and stops at the first match or after the last entry.
// the memory's single read port and single write port move one entry per walk step.
// sync reset clears the count and control, not the list contents; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_item_value,
  input  wire logic [8:0]  in_list_position,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [8:0]       out_found_position,
  output logic [8:0]       out_list_length
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > ple_pkg::FIELD_W) ? CW : ple_pkg::FIELD_W;

  typedef enum logic {S_IDLE, S_WALK} state_t;
  typedef enum logic [1:0] {M_INS, M_DEL, M_SRCH} mode_t;

  // list storage
  logic [ple_pkg::DATA_W-1:0] mem [DEPTH];
  logic [ple_pkg::DATA_W-1:0] rdata_r;

  state_t            state_r;
  mode_t             mode_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     left_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     rd_addr_r;
  logic              rd_vld_r;
  logic [AW-1:0]     idx_r;
  logic [31:0]       val_r;
  logic              out_valid_r;
  ple_pkg::status_t  status_r;
  logic [8:0]        found_r;
  logic [8:0]        length_r;

  ple_pkg::op_t      op_in;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     pos_x;
  logic              full;
  logic              empty;
  logic              pos_zero;
  logic              ins_bad;
  logic              del_bad;
  logic [AW-1:0]     pos_idx;
  logic [AW-1:0]     last_idx;
  logic              imm;
  ple_pkg::status_t  imm_status;
  mode_t             st_mode;
  logic [AW-1:0]     st_idx;
  logic [CW-1:0]     st_left;
  logic [AW-1:0]     st_addr;
  logic              walk;
  logic              match;
  logic              issue;
  logic              finish;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [31:0]       mem_wd;
  logic [CW-1:0]     cnt_fin;
  logic [XW-1:0]     fin_x;
  logic [XW-1:0]     found_x;

  // operand checks on the incoming beat
  always_comb begin
    op_in    = ple_pkg::op_t'(in_op);
    cnt_x    = XW'(cnt_r);
    pos_x    = XW'(in_list_position);
    full     = (cnt_r == CW'(DEPTH));
    empty    = (cnt_r == '0);
    pos_zero = (in_list_position == '0);
    ins_bad  = pos_zero || ({1'b0, pos_x} > ({1'b0, cnt_x} + (XW + 1)'(1)));
    del_bad  = pos_zero || (pos_x > cnt_x);
    pos_idx  = AW'(pos_x - XW'(1));
    last_idx = AW'(cnt_r - CW'(1));
  end

  // decode: immediate result or walk setup
  always_comb begin
    imm        = 1'b0;
    imm_status = ple_pkg::ST_OK;
    st_mode    = M_SRCH;
    st_idx     = '0;
    unique case (op_in)
      ple_pkg::OP_INS_END: begin
        imm = full; imm_status = ple_pkg::ST_FULL;
        st_mode = M_INS; st_idx = AW'(cnt_r);
      end
      ple_pkg::OP_INS_BEGIN: begin
        imm = full; imm_status = ple_pkg::ST_FULL;
        st_mode = M_INS;
      end
      ple_pkg::OP_INS_AT: begin
        imm = ins_bad || full;
        imm_status = ins_bad ? ple_pkg::ST_RANGE : ple_pkg::ST_FULL;
        st_mode = M_INS; st_idx = pos_idx;
      end
      ple_pkg::OP_DEL_FIRST: begin
        imm = empty; imm_status = ple_pkg::ST_EMPTY;
        st_mode = M_DEL;
      end
      ple_pkg::OP_DEL_LAST: begin
        imm = empty; imm_status = ple_pkg::ST_EMPTY;
        st_mode = M_DEL; st_idx = last_idx;
      end
      ple_pkg::OP_DEL_AT: begin
        imm = empty || del_bad;
        imm_status = empty ? ple_pkg::ST_EMPTY : ple_pkg::ST_RANGE;
        st_mode = M_DEL; st_idx = pos_idx;
      end
      ple_pkg::OP_SEARCH: begin
        st_mode = M_SRCH;
      end
      ple_pkg::OP_COUNT: begin
        imm = 1'b1; imm_status = ple_pkg::ST_OK;
      end
      default: begin
        imm = 1'b1;
      end
    endcase
    // reads to do and first read address per mode
    case (st_mode)
      M_INS: begin
        st_left = cnt_r - CW'(st_idx);
        st_addr = last_idx;
      end
      M_DEL: begin
        st_left = cnt_r - CW'(st_idx) - CW'(1);
        st_addr = st_idx + AW'(1);
      end
      default: begin
        st_left = cnt_r;
        st_addr = '0;
      end
    endcase
  end

  // walk control
  always_comb begin
    walk    = (state_r == S_WALK);
    match   = walk && (mode_r == M_SRCH) && rd_vld_r && (rdata_r == val_r);
    issue   = walk && (left_r != '0) && !match;
    finish  = walk && (match || ((left_r == '0) && !rd_vld_r));
    mem_we  = 1'b0;
    mem_wa  = idx_r;
    mem_wd  = val_r;
    if (walk && rd_vld_r && (mode_r != M_SRCH)) begin
      mem_we = 1'b1;
      mem_wa = (mode_r == M_INS) ? rd_addr_r + AW'(1) : rd_addr_r - AW'(1);
      mem_wd = rdata_r;
    end else if (finish && (mode_r == M_INS)) begin
      mem_we = 1'b1;
    end
    case (mode_r)
      M_INS:   cnt_fin = cnt_r + CW'(1);
      M_DEL:   cnt_fin = cnt_r - CW'(1);
      default: cnt_fin = cnt_r;
    endcase
    fin_x   = XW'(cnt_fin);
    found_x = XW'(rd_addr_r) + XW'(1);
  end

  // list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rdata_r <= mem[addr_r];
    end
  end

  // sequencer state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= issue;
      if (issue) begin
        rd_addr_r <= addr_r;
        addr_r    <= (mode_r == M_INS) ? addr_r - AW'(1) : addr_r + AW'(1);
        left_r    <= left_r - CW'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (imm) begin
              out_valid_r <= 1'b1;
              status_r    <= imm_status;
              found_r     <= '0;
              length_r    <= cnt_x[8:0];
            end else begin
              state_r <= S_WALK;
              mode_r  <= st_mode;
              idx_r   <= st_idx;
              val_r   <= in_item_value;
              left_r  <= st_left;
              addr_r  <= st_addr;
            end
          end
        end
        S_WALK: begin
          if (finish) begin
            state_r     <= S_IDLE;
            cnt_r       <= cnt_fin;
            out_valid_r <= 1'b1;
            length_r    <= fin_x[8:0];
            if (match) begin
              status_r <= ple_pkg::ST_OK;
              found_r  <= found_x[8:0];
            end else begin
              status_r <= (mode_r == M_SRCH) ? ple_pkg::ST_NOTFOUND : ple_pkg::ST_OK;
              found_r  <= '0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // port drive
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_list_length    = length_r;

  // checks
  `PLE_ASSERT_NEXT(a_beat_answered, start && !busy, busy || out_valid)
  `PLE_ASSERT_NOW(a_walk_end_reports, $fell(busy) && $past(rst_n), out_valid)
  `PLE_ASSERT_NOW(a_count_bounded, 1'b1, cnt_r <= CW'(DEPTH))
  `PLE_ASSERT_NOW(a_write_only_busy, mem_we, busy)

endmodule

`default_nettype wire
